[design/pocl_pkg.sv]
// Shared types and constants for the PNG offset chunk locator.
// No dependencies; imported by every pocl module.
`timescale 1ns / 1ps
`default_nettype none

package pocl_pkg;

   localparam int POSITION_BITS = 24;
   localparam int StartBits     = 24;
   localparam int OffsetBits    = 32;
   localparam int CountBits     = 4;
   localparam int RspDataBits   = 96;
   localparam int WideBits      = (POSITION_BITS > StartBits) ? POSITION_BITS : StartBits;

   localparam logic [POSITION_BITS-1:0] PosMax  = {POSITION_BITS{1'b1}};
   localparam logic [POSITION_BITS-1:0] PosTag  = POSITION_BITS'(7);
   localparam logic [StartBits-1:0]     StartMax = {StartBits{1'b1}};
   localparam logic [CountBits-1:0]     CaptureBytes = CountBits'(8);

   // "IDAT" and "grAb", first byte in the high lane
   localparam logic [31:0] TagImage  = {8'h49, 8'h44, 8'h41, 8'h54};
   localparam logic [31:0] TagOffset = {8'h67, 8'h72, 8'h41, 8'h62};

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } item_type;

   typedef struct packed {
      logic                         truncated;
      logic [StartBits-1:0]         chunk_start;
      logic signed [OffsetBits-1:0] y_offset;
      logic signed [OffsetBits-1:0] x_offset;
      logic                         found;
   } result_type;

   // Saturate a position to the output field width.
   function automatic logic [StartBits-1:0] clip_start(input logic [POSITION_BITS-1:0] pos);
      logic [WideBits-1:0] wide;
      wide = WideBits'(pos);
      if (wide > WideBits'(StartMax)) begin
         return StartMax;
      end
      return StartBits'(wide);
   endfunction

endpackage

`default_nettype wire

[design/pocl_in_reg.sv]
// Input register: holds one request beat until the scanner takes it.
// Depends on pocl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pocl_in_reg (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [7:0]         req_tdata,   // [7:0] data_byte
   input  wire logic               req_tlast,   // final_byte
   input  wire logic               take,
   output logic                    hold_valid,
   output pocl_pkg::item_type      hold_item
);
   import pocl_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;

   assign req_tready = !valid_ff || take;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload: load on every accepted beat
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= '{data_byte: req_tdata, final_byte: req_tlast};
      end
   end

   assign hold_valid = valid_ff;
   assign hold_item  = item_ff;

endmodule

`default_nettype wire

[design/pocl_scanner.sv]
// Tag window, byte counter and offset capture; builds the result on the final byte.
// Depends on pocl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pocl_scanner (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 hold_valid,
   input  wire pocl_pkg::item_type   hold_item,
   input  wire logic                 out_free,
   output logic                      take,
   output logic                      emit,
   output pocl_pkg::result_type      result
);
   import pocl_pkg::*;

   // control state
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [CountBits-1:0]     remain_ff, remain_in;
   logic                     stopped_ff, stopped_in;
   logic                     found_ff, found_in;
   // payload state
   logic [31:0]              window_ff, window_in;
   logic [63:0]              shift_ff, shift_in;
   logic [OffsetBits-1:0]    held_x_ff, held_x_in;
   logic [OffsetBits-1:0]    held_y_ff, held_y_in;
   logic [POSITION_BITS-1:0] held_start_ff, held_start_in;
   logic [POSITION_BITS-1:0] pending_ff, pending_in;

   assign take = hold_valid && (!hold_item.final_byte || out_free);
   assign emit = take && hold_item.final_byte;

   always_comb begin
      window_in     = {window_ff[23:0], hold_item.data_byte};
      shift_in      = shift_ff;
      remain_in     = remain_ff;
      stopped_in    = stopped_ff;
      found_in      = found_ff;
      held_x_in     = held_x_ff;
      held_y_in     = held_y_ff;
      held_start_in = held_start_ff;
      pending_in    = pending_ff;
      pos_in        = (pos_ff < PosMax) ? pos_ff + POSITION_BITS'(1) : pos_ff;

      if (!stopped_ff) begin
         if (remain_ff != '0) begin
            shift_in  = {shift_ff[55:0], hold_item.data_byte};
            remain_in = remain_ff - CountBits'(1);
            if (remain_ff == CountBits'(1)) begin
               held_x_in     = shift_in[63:32];
               held_y_in     = shift_in[31:0];
               held_start_in = pending_ff;
               found_in      = 1'b1;
            end
         end else if (pos_ff >= PosTag) begin
            if (window_in == TagImage) begin
               stopped_in = 1'b1;
            end else if (window_in == TagOffset) begin
               remain_in  = CaptureBytes;
               shift_in   = '0;
               pending_in = pos_ff - PosTag;
            end
         end
      end
   end

   // result uses the post-update state of the final beat
   always_comb begin
      result.found       = found_in;
      result.x_offset    = found_in ? held_x_in : '0;
      result.y_offset    = found_in ? held_y_in : '0;
      result.chunk_start = found_in ? clip_start(held_start_in) : '0;
      result.truncated   = (remain_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         remain_ff  <= '0;
         stopped_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else if (take) begin
         if (hold_item.final_byte) begin
            // start the next file from a clean state
            pos_ff     <= '0;
            remain_ff  <= '0;
            stopped_ff <= 1'b0;
            found_ff   <= 1'b0;
         end else begin
            pos_ff     <= pos_in;
            remain_ff  <= remain_in;
            stopped_ff <= stopped_in;
            found_ff   <= found_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         window_ff     <= window_in;
         shift_ff      <= shift_in;
         held_x_ff     <= held_x_in;
         held_y_ff     <= held_y_in;
         held_start_ff <= held_start_in;
         pending_ff    <= pending_in;
      end
   end

endmodule

`default_nettype wire

[design/pocl_out_reg.sv]
// Result register: holds one response beat until the sink takes it.
// Depends on pocl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pocl_out_reg (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               emit,
   input  wire pocl_pkg::result_type               result,
   output logic                                    out_free,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [0] found, [32:1] x_offset, [64:33] y_offset, [88:65] chunk_start,
   // [89] truncated, [95:90] zero
   output logic [pocl_pkg::RspDataBits-1:0]        rsp_tdata
);
   import pocl_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign out_free = !valid_ff || rsp_tready;
   assign valid_in = emit || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RspDataBits'(data_ff);

endmodule

`default_nettype wire

[design/png_offset_chunk_locator_core.sv]
// PNG offset chunk locator: scans a PNG byte stream for a grAb chunk before IDAT.
// Top level; depends on pocl_pkg, pocl_in_reg, pocl_scanner and pocl_out_reg.
`timescale 1ns / 1ps
`default_nettype none

// Feed the file one byte per beat with tlast on its final byte. The block
// takes one byte every clock while the input is not stalled; a byte passes
// an input register and then the window compare and capture logic, and the
// result beat is loaded into the result register as the final byte leaves
// the input register. Only a final byte meeting a still-occupied result
// register stalls the input. The result reports whether a complete grAb
// chunk came before IDAT, its two signed offsets, the position of the
// chunk's length field and whether the file ended inside the offset bytes.
// After the final byte the block starts over for the next file.
module png_offset_chunk_locator_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [7:0]                    req_tdata,   // [7:0] data_byte
   input  wire logic                          req_tlast,   // final_byte
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [0] found, [32:1] x_offset, [64:33] y_offset, [88:65] chunk_start,
   // [89] truncated, [95:90] zero
   output logic [pocl_pkg::RspDataBits-1:0]   rsp_tdata
);
   import pocl_pkg::*;

   logic       take, emit, out_free, hold_valid;
   item_type   hold_item;
   result_type result;

   pocl_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .take       (take),
      .hold_valid (hold_valid),
      .hold_item  (hold_item)
   );

   pocl_scanner u_scanner (
      .clock      (clock),
      .reset      (reset),
      .hold_valid (hold_valid),
      .hold_item  (hold_item),
      .out_free   (out_free),
      .take       (take),
      .emit       (emit),
      .result     (result)
   );

   pocl_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .emit       (emit),
      .result     (result),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
